// ===== rtl/gtpsc_pkg.sv =====
package gtpsc_pkg;

	// iteration count of the arctangent unit, 8 to 32
	localparam int CORDIC_STEPS = 16;

	localparam int ATAN_N = 32;
	localparam int ITER_W = $clog2(ATAN_N);
	localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STEPS - 1);

	// vector and angle accumulator widths of the arctangent unit
	localparam int CORDIC_W = 36;
	localparam int ANGLE_W = 28;

	// radicand width of the square root unit
	localparam int SQ_W = 63;

	localparam int PI_Q13 = 25736;
	localparam int TWO_PI_Q13 = 51472;
	localparam int HALF_PI_Q24 = 26353589;
	localparam int ROUND_Q24 = 1024;
	localparam int ONE_Q28 = 268435456;
	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

	localparam logic signed [ANGLE_W-1:0] ATAN_Q24 [ATAN_N] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
		28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
		28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
		28'sd256, 28'sd128, 28'sd64, 28'sd32,
		28'sd16, 28'sd8, 28'sd4, 28'sd2,
		28'sd1, 28'sd0, 28'sd0, 28'sd0,
		28'sd0, 28'sd0, 28'sd0, 28'sd0
	};

	typedef enum logic [1:0] {
		CMD_ODOM   = 2'd0,
		CMD_ARM    = 2'd1,
		CMD_CANCEL = 2'd2
	} gtpsc_cmd_t;

	typedef enum logic [2:0] {
		CFG_GOAL_X   = 3'd0,
		CFG_GOAL_Y   = 3'd1,
		CFG_GOAL_HDG = 3'd2,
		CFG_LIN_LIM  = 3'd3,
		CFG_ANG_LIM  = 3'd4,
		CFG_POS_TOL  = 3'd5,
		CFG_HDG_TOL  = 3'd6
	} gtpsc_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_YAW,
		ST_BRG,
		ST_ERR,
		ST_DECIDE,
		ST_EMIT
	} gtpsc_state_t;

	// fold an angle difference back into plus or minus pi
	function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] a);
		logic signed [17:0] r;
		r = a;
		if (a > 18'(PI_Q13)) begin
			r = a - 18'(TWO_PI_Q13);
		end else if (a < -18'(PI_Q13)) begin
			r = a + 18'(TWO_PI_Q13);
		end
		return r[15:0];
	endfunction

endpackage

// ===== rtl/gtpsc_cmd_if.sv =====
interface gtpsc_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] orient_x;
	logic signed [15:0] orient_y;
	logic signed [15:0] orient_z;
	logic signed [15:0] orient_w;

	modport source (
		output valid, command, pos_x, pos_y, orient_x, orient_y, orient_z, orient_w,
		input  ready
	);
	modport sink (
		input  valid, command, pos_x, pos_y, orient_x, orient_y, orient_z, orient_w,
		output ready
	);
endinterface

// ===== rtl/gtpsc_res_if.sv =====
interface gtpsc_res_if;
	logic               valid;
	logic               ready;
	logic [30:0]        forward_speed;
	logic signed [15:0] turn_rate;
	logic               goal_reached;

	modport source (
		output valid, forward_speed, turn_rate, goal_reached,
		input  ready
	);
	modport sink (
		input  valid, forward_speed, turn_rate, goal_reached,
		output ready
	);
endinterface

// ===== rtl/gtpsc_cordic.sv =====
module gtpsc_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [gtpsc_pkg::CORDIC_W-1:0] x_in,
	input  logic signed [gtpsc_pkg::CORDIC_W-1:0] y_in,
	output logic                                  done,
	output logic signed [15:0]                    angle
);

	localparam int CW = gtpsc_pkg::CORDIC_W;
	localparam int ZW = gtpsc_pkg::ANGLE_W;

	logic                             run_q;
	logic                             done_q;
	logic [gtpsc_pkg::ITER_W-1:0]     cnt_q;
	logic                             zero_q;
	logic signed [CW-1:0]             x_q, y_q;
	logic signed [ZW-1:0]             z_q;

	logic signed [CW-1:0]             x0, y0, x_n, y_n, sx, sy;
	logic signed [ZW-1:0]             z0, z_n, rnd;

	// move the left half plane onto the right half before rotating
	always_comb begin
		x0 = x_in;
		y0 = y_in;
		z0 = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x0 = y_in;
				y0 = -x_in;
				z0 = ZW'(gtpsc_pkg::HALF_PI_Q24);
			end else begin
				x0 = -y_in;
				y0 = x_in;
				z0 = -ZW'(gtpsc_pkg::HALF_PI_Q24);
			end
		end
	end

	always_comb begin
		sx = x_q >>> cnt_q;
		sy = y_q >>> cnt_q;
		if (y_q > 0) begin
			x_n = x_q + sy;
			y_n = y_q - sx;
			z_n = z_q + gtpsc_pkg::ATAN_Q24[cnt_q];
		end else begin
			x_n = x_q - sy;
			y_n = y_q + sx;
			z_n = z_q - gtpsc_pkg::ATAN_Q24[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == gtpsc_pkg::CORDIC_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (run_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	// round Q24 to Q13 half up, then limit to plus or minus pi
	always_comb begin
		rnd = (z_q + ZW'(gtpsc_pkg::ROUND_Q24)) >>> 11;
		if (zero_q) begin
			angle = '0;
		end else if (rnd > ZW'(gtpsc_pkg::PI_Q13)) begin
			angle = 16'(gtpsc_pkg::PI_Q13);
		end else if (rnd < -ZW'(gtpsc_pkg::PI_Q13)) begin
			angle = -16'(gtpsc_pkg::PI_Q13);
		end else begin
			angle = rnd[15:0];
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/gtpsc_isqrt.sv =====
module gtpsc_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gtpsc_pkg::SQ_W-1:0]   radicand,
	output logic                         done,
	output logic [30:0]                  root
);

	logic        run_q;
	logic        done_q;
	logic [63:0] n_q, res_q, bit_q;
	logic [63:0] trial;
	logic        take;

	// res has no bits at or below the current bit, so the add is an OR
	assign trial = res_q | bit_q;
	assign take  = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= 64'(radicand);
			res_q <= '0;
			bit_q <= 64'(1) << 62;
		end else if (run_q) begin
			bit_q <= bit_q >> 2;
			if (take) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) | bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign root = (res_q[63:31] != '0) ? gtpsc_pkg::SAT31 : res_q[30:0];
	assign done = done_q;

endmodule

// ===== rtl/go_to_pose_steering_controller.sv =====
// Arm, unknown and disarmed odometry commands give no result; a cancel goes to the emit state
// and then loads a stop beat into the output register. An odometry sample with a goal armed
// runs the multiply sequence, the yaw pass of the shared CORDIC unit, then the bearing pass
// beside the 32-step square root, then the error and decide states before its beat is emitted.
// Input is ready again once the beat is loaded; a stalled beat holds input off. arst_n clears
// state and loads reg resets.
module go_to_pose_steering_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	gtpsc_cmd_if.sink      cmd,
	gtpsc_res_if.source    res
);

	localparam int CW = gtpsc_pkg::CORDIC_W;

	// multiply sequence steps
	localparam logic [2:0] MS_WZ  = 3'd0;
	localparam logic [2:0] MS_XY  = 3'd1;
	localparam logic [2:0] MS_YY  = 3'd2;
	localparam logic [2:0] MS_ZZ  = 3'd3;
	localparam logic [2:0] MS_DX  = 3'd4;
	localparam logic [2:0] MS_DY  = 3'd5;
	localparam logic [2:0] MS_SUM = 3'd6;

	gtpsc_pkg::gtpsc_state_t state_q, state_d;

	logic signed [31:0] goal_x_q, goal_y_q;
	logic signed [15:0] goal_hdg_q;
	logic [30:0]        lin_lim_q, pos_tol_q;
	logic [14:0]        ang_lim_q, hdg_tol_q;
	logic               armed_q;

	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [32:0] dx_q, dy_q;
	logic [30:0]        adx_q, ady_q;
	logic               sat_q;
	logic [2:0]         mul_cnt_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_d, prod_q, sum_q, acc;
	logic signed [CW-1:0] num_q, den_q;
	logic [gtpsc_pkg::SQ_W-1:0] sq_q;

	logic signed [15:0] yaw_q, bearing_q, head_err_q, orient_err_q;
	logic [30:0]        dist_q;
	logic               brg_ok_q, dist_ok_q;

	logic [30:0]        pend_speed_q;
	logic signed [15:0] pend_turn_q;
	logic               pend_reached_q;
	logic               out_valid_q;
	logic [30:0]        out_speed_q;
	logic signed [15:0] out_turn_q;
	logic               out_reached_q;

	logic               accept;
	logic               emit;
	logic               cordic_start, cordic_done, sqrt_start, sqrt_done;
	logic signed [CW-1:0] cordic_x, cordic_y;
	logic signed [15:0] cordic_angle;
	logic [30:0]        sqrt_root;
	logic [32:0]        adx, ady;

	logic               pos_ok, yaw_ok, head_ok;
	logic [15:0]        abs_head, abs_orient;
	logic [30:0]        lin;
	logic signed [16:0] turn_src, lim17;
	logic signed [15:0] turn;

	assign cmd.ready = (state_q == gtpsc_pkg::ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign emit      = (state_q == gtpsc_pkg::ST_EMIT) && (!out_valid_q || res.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			goal_hdg_q <= '0;
			lin_lim_q  <= 31'd13107;
			ang_lim_q  <= 15'd4096;
			pos_tol_q  <= 31'd3277;
			hdg_tol_q  <= 15'd819;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gtpsc_pkg::CFG_GOAL_X:   goal_x_q   <= cfg_data;
				gtpsc_pkg::CFG_GOAL_Y:   goal_y_q   <= cfg_data;
				gtpsc_pkg::CFG_GOAL_HDG: goal_hdg_q <= cfg_data[15:0];
				gtpsc_pkg::CFG_LIN_LIM:  lin_lim_q  <= cfg_data[30:0];
				gtpsc_pkg::CFG_ANG_LIM:  ang_lim_q  <= cfg_data[14:0];
				gtpsc_pkg::CFG_POS_TOL:  pos_tol_q  <= cfg_data[30:0];
				gtpsc_pkg::CFG_HDG_TOL:  hdg_tol_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtpsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cordic_start = 1'b0;
		sqrt_start   = 1'b0;
		case (state_q)
			gtpsc_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.command == gtpsc_pkg::CMD_CANCEL) begin
						state_d = gtpsc_pkg::ST_EMIT;
					end else if (cmd.command == gtpsc_pkg::CMD_ODOM && armed_q) begin
						state_d = gtpsc_pkg::ST_MUL;
					end
				end
			end
			gtpsc_pkg::ST_MUL: begin
				if (mul_cnt_q == MS_SUM) begin
					cordic_start = 1'b1;
					state_d      = gtpsc_pkg::ST_YAW;
				end
			end
			gtpsc_pkg::ST_YAW: begin
				if (cordic_done) begin
					cordic_start = 1'b1;
					sqrt_start   = 1'b1;
					state_d      = gtpsc_pkg::ST_BRG;
				end
			end
			gtpsc_pkg::ST_BRG: begin
				if (brg_ok_q && dist_ok_q) begin
					state_d = gtpsc_pkg::ST_ERR;
				end
			end
			gtpsc_pkg::ST_ERR:    state_d = gtpsc_pkg::ST_DECIDE;
			gtpsc_pkg::ST_DECIDE: state_d = gtpsc_pkg::ST_EMIT;
			gtpsc_pkg::ST_EMIT: begin
				if (emit) begin
					state_d = gtpsc_pkg::ST_IDLE;
				end
			end
			default: state_d = gtpsc_pkg::ST_IDLE;
		endcase
	end

	// goal state: arm, cancel, and drop on arrival
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (accept && cmd.command == gtpsc_pkg::CMD_ARM) begin
			armed_q <= 1'b1;
		end else if (accept && cmd.command == gtpsc_pkg::CMD_CANCEL) begin
			armed_q <= 1'b0;
		end else if (state_q == gtpsc_pkg::ST_DECIDE && pos_ok && yaw_ok) begin
			armed_q <= 1'b0;
		end
	end

	// sample capture and goal offset
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= cmd.orient_x;
			qy_q <= cmd.orient_y;
			qz_q <= cmd.orient_z;
			qw_q <= cmd.orient_w;
			dx_q <= 33'(goal_x_q) - 33'(cmd.pos_x);
			dy_q <= 33'(goal_y_q) - 33'(cmd.pos_y);
		end
	end

	// shared multiplier: quaternion terms, then the squared offsets
	assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

	always_comb begin
		case (mul_cnt_q)
			MS_WZ: begin
				mul_a = 32'(qw_q);
				mul_b = 32'(qz_q);
			end
			MS_XY: begin
				mul_a = 32'(qx_q);
				mul_b = 32'(qy_q);
			end
			MS_YY: begin
				mul_a = 32'(qy_q);
				mul_b = 32'(qy_q);
			end
			MS_ZZ: begin
				mul_a = 32'(qz_q);
				mul_b = 32'(qz_q);
			end
			MS_DX: begin
				mul_a = signed'({1'b0, adx_q});
				mul_b = signed'({1'b0, adx_q});
			end
			MS_DY: begin
				mul_a = signed'({1'b0, ady_q});
				mul_b = signed'({1'b0, ady_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;
	assign acc    = sum_q + prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
		end else if (accept) begin
			mul_cnt_q <= '0;
		end else if (state_q == gtpsc_pkg::ST_MUL) begin
			mul_cnt_q <= mul_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gtpsc_pkg::ST_MUL) begin
			prod_q <= prod_d;
			case (mul_cnt_q)
				MS_WZ: begin
					adx_q <= adx[30:0];
					ady_q <= ady[30:0];
					sat_q <= (adx[32:31] != '0) || (ady[32:31] != '0);
				end
				MS_XY:   sum_q <= prod_q;
				MS_YY:   num_q <= CW'(acc <<< 1);
				MS_ZZ:   sum_q <= prod_q;
				MS_DX:   den_q <= CW'(64'(gtpsc_pkg::ONE_Q28) - (acc <<< 1));
				MS_DY:   sum_q <= prod_q;
				MS_SUM:  sq_q  <= gtpsc_pkg::SQ_W'(acc);
				default: ;
			endcase
		end
	end

	// yaw pass takes the quaternion terms, bearing pass the goal offset
	assign cordic_x = (state_q == gtpsc_pkg::ST_MUL) ? den_q : CW'(dx_q);
	assign cordic_y = (state_q == gtpsc_pkg::ST_MUL) ? num_q : CW'(dy_q);

	gtpsc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x_in   (cordic_x),
		.y_in   (cordic_y),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	gtpsc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brg_ok_q  <= 1'b0;
			dist_ok_q <= 1'b0;
		end else if (state_q == gtpsc_pkg::ST_YAW) begin
			brg_ok_q  <= 1'b0;
			dist_ok_q <= 1'b0;
		end else if (state_q == gtpsc_pkg::ST_BRG) begin
			if (cordic_done) begin
				brg_ok_q <= 1'b1;
			end
			if (sqrt_done) begin
				dist_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gtpsc_pkg::ST_YAW && cordic_done) begin
			yaw_q <= cordic_angle;
		end
		if (state_q == gtpsc_pkg::ST_BRG && cordic_done) begin
			bearing_q <= cordic_angle;
		end
		if (state_q == gtpsc_pkg::ST_BRG && sqrt_done) begin
			dist_q <= sat_q ? gtpsc_pkg::SAT31 : sqrt_root;
		end
		if (state_q == gtpsc_pkg::ST_ERR) begin
			head_err_q   <= gtpsc_pkg::wrap_angle(18'(bearing_q) - 18'(yaw_q));
			orient_err_q <= gtpsc_pkg::wrap_angle(18'(goal_hdg_q) - 18'(yaw_q));
		end
	end

	// steering decision
	assign abs_head   = head_err_q[15] ? 16'(-head_err_q) : 16'(head_err_q);
	assign abs_orient = orient_err_q[15] ? 16'(-orient_err_q) : 16'(orient_err_q);
	assign pos_ok     = dist_q < pos_tol_q;
	assign yaw_ok     = abs_orient < {1'b0, hdg_tol_q};
	assign head_ok    = abs_head <= {1'b0, hdg_tol_q};
	assign lin        = (dist_q < lin_lim_q) ? dist_q : lin_lim_q;
	assign turn_src   = pos_ok ? 17'(orient_err_q) : 17'(head_err_q);
	assign lim17      = signed'({2'b00, ang_lim_q});

	always_comb begin
		if (turn_src > lim17) begin
			turn = lim17[15:0];
		end else if (turn_src < -lim17) begin
			turn = 16'(-lim17);
		end else begin
			turn = turn_src[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_speed_q   <= '0;
			pend_turn_q    <= '0;
			pend_reached_q <= 1'b0;
		end else if (state_q == gtpsc_pkg::ST_DECIDE) begin
			if (pos_ok && yaw_ok) begin
				pend_speed_q   <= '0;
				pend_turn_q    <= '0;
				pend_reached_q <= 1'b1;
			end else begin
				pend_speed_q   <= (!pos_ok && head_ok) ? lin : '0;
				pend_turn_q    <= turn;
				pend_reached_q <= 1'b0;
			end
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_speed_q   <= pend_speed_q;
			out_turn_q    <= pend_turn_q;
			out_reached_q <= pend_reached_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.forward_speed = out_speed_q;
	assign res.turn_rate     = out_turn_q;
	assign res.goal_reached  = out_reached_q;

endmodule
